/* src/htes_pkg.sv */
// Shared types and constants for the hold-extended trigger slot unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package htes_pkg;

  localparam int unsigned SLOTS_DEF       = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CMD_W    = 8;
  localparam int unsigned EFF_W    = 8;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned HOLD_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_PRESS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEPTED_CMD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTEND       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_LIMIT   = 2'd3;

  localparam logic [CMD_W-1:0] ACCEPTED_CMD_RST = 8'd0;
  localparam logic [MS_W-1:0]  MIN_DURATION_RST = 16'd1000;
  localparam logic [MS_W-1:0]  EXTEND_RST       = 16'd500;
  localparam logic [MS_W-1:0]  PLAY_LIMIT_RST   = 16'd10000;

  localparam logic [HOLD_W-1:0] HOLD_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2,
    OP_BADCMD  = 2'd3
  } op_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_START    = 3'd0,
    ACT_STOP     = 3'd1,
    ACT_EXTRA    = 3'd2,
    ACT_NOSLOT   = 3'd3,
    ACT_BADCMD   = 3'd4,
    ACT_RELEASED = 3'd5
  } act_e;

  typedef struct packed {
    op_e              op;
    logic [EFF_W-1:0] effect;
    logic [MS_W-1:0]  elapsed;
  } item_t;

  typedef struct packed {
    logic [MS_W-1:0] min_duration;
    logic [MS_W-1:0] extend;
    logic [MS_W-1:0] play_limit;
  } cfg_t;

endpackage

`default_nettype wire

/* src/hold_extended_trigger_slots_unit.sv */
// Top level: config registers, front end, item queue and slot engine (htes_pkg,
// htes_front, htes_fifo, htes_back). The engine pops one item at a time, when idle;
// press and release walk the slot table then apply, a tick walks it then flushes,
// a bad command goes straight to apply. The walk takes one entry per cycle unless a
// stop result is held; a stalled result holds the engine until it is taken.
// Reset (async, active low): slots free and cleared, queue empty, config 0/1000/500/10000.
`default_nettype none

module hold_extended_trigger_slots_unit
  import htes_pkg::*;
#(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  var logic                 clk_i,
  input  var logic                 rst_ni,
  input  var logic                 cfg_valid_i,
  output var logic                 cfg_ready_o,
  input  var logic [CFG_IDX_W-1:0] cfg_index_i,
  input  var logic [MS_W-1:0]      cfg_data_i,
  input  var logic                 in_valid_i,
  output var logic                 in_stall_o,
  input  var logic [MODE_W-1:0]    mode_i,
  input  var logic [CMD_W-1:0]     command_i,
  input  var logic [EFF_W-1:0]     effect_id_i,
  input  var logic [MS_W-1:0]      elapsed_ms_i,
  output var logic                 out_valid_o,
  input  var logic                 out_stall_i,
  output var logic [ACT_W-1:0]     action_o,
  output var logic [EFF_W-1:0]     effect_out_o,
  output var logic [SLOT_W-1:0]    slot_out_o,
  output var logic [MS_W-1:0]      play_ms_o,
  output var logic                 last_o
);

  logic [CMD_W-1:0] accepted_cmd_q;
  cfg_t             cfg_q;

  logic  q_push, q_pop, q_full, q_empty;
  item_t q_in, q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_cmd_q     <= ACCEPTED_CMD_RST;
      cfg_q.min_duration <= MIN_DURATION_RST;
      cfg_q.extend       <= EXTEND_RST;
      cfg_q.play_limit   <= PLAY_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ACCEPTED_CMD: accepted_cmd_q     <= cfg_data_i[CMD_W-1:0];
        REG_MIN_DURATION: cfg_q.min_duration <= cfg_data_i;
        REG_EXTEND:       cfg_q.extend       <= cfg_data_i;
        REG_PLAY_LIMIT:   cfg_q.play_limit   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  htes_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .command_i      (command_i),
    .effect_id_i    (effect_id_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .accepted_cmd_i (accepted_cmd_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_in)
  );

  htes_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  htes_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .cfg_i        (cfg_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .action_o     (action_o),
    .effect_out_o (effect_out_o),
    .slot_out_o   (slot_out_o),
    .play_ms_o    (play_ms_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

/* src/htes_front.sv */
// Front end: accepts items, checks the command code, classifies or drops them.
// Depends on htes_pkg; feeds htes_fifo.
`default_nettype none

module htes_front
  import htes_pkg::*;
(
  input  var logic              in_valid_i,
  output var logic              in_stall_o,
  input  var logic [MODE_W-1:0] mode_i,
  input  var logic [CMD_W-1:0]  command_i,
  input  var logic [EFF_W-1:0]  effect_id_i,
  input  var logic [MS_W-1:0]   elapsed_ms_i,
  input  var logic [CMD_W-1:0]  accepted_cmd_i,
  input  var logic              q_full_i,
  output var logic              q_push_o,
  output var item_t             q_item_o
);

  logic cmd_ok;
  logic keep;

  assign cmd_ok = (command_i == accepted_cmd_i);

  always_comb begin
    keep            = 1'b1;
    q_item_o.effect  = effect_id_i;
    q_item_o.elapsed = elapsed_ms_i;
    q_item_o.op      = OP_TICK;
    case (mode_i)
      MODE_PRESS:   q_item_o.op = cmd_ok ? OP_PRESS : OP_BADCMD;
      MODE_RELEASE: q_item_o.op = cmd_ok ? OP_RELEASE : OP_BADCMD;
      MODE_TICK:    q_item_o.op = OP_TICK;
      default:      keep = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

`default_nettype wire

/* src/htes_fifo.sv */
// Short item queue between the front end and the slot engine.
// Depends on htes_pkg for the item type.
`default_nettype none

module htes_fifo
  import htes_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  var logic  clk_i,
  input  var logic  rst_ni,
  input  var logic  push_i,
  input  var item_t push_item_i,
  input  var logic  pop_i,
  output var item_t head_o,
  output var logic  full_o,
  output var logic  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

/* src/htes_back.sv */
// Slot engine: walks the slot table one entry per cycle unless stalled; emits results.
// Depends on htes_pkg; pops items from htes_fifo.
`default_nettype none

module htes_back
  import htes_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  var logic              clk_i,
  input  var logic              rst_ni,
  input  var logic              q_empty_i,
  input  var item_t             q_head_i,
  output var logic              q_pop_o,
  input  var cfg_t              cfg_i,
  output var logic              out_valid_o,
  input  var logic              out_stall_i,
  output var logic [ACT_W-1:0]  action_o,
  output var logic [EFF_W-1:0]  effect_out_o,
  output var logic [SLOT_W-1:0] slot_out_o,
  output var logic [MS_W-1:0]   play_ms_o,
  output var logic              last_o
);

  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CNT_W-1:0] NONE = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SLOTS - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_APPLY = 5'b00100,
    ST_TICK  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic              busy_q [SLOTS];
  logic              busy_d [SLOTS];
  logic [EFF_W-1:0]  eff_q  [SLOTS];
  logic [EFF_W-1:0]  eff_d  [SLOTS];
  logic [HOLD_W-1:0] hold_q [SLOTS];
  logic [HOLD_W-1:0] hold_d [SLOTS];
  logic [MS_W-1:0]   rem_q  [SLOTS];
  logic [MS_W-1:0]   rem_d  [SLOTS];

  item_t             op_q, op_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  match_q, match_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic              pend_v_q, pend_v_d;
  logic [EFF_W-1:0]  pend_eff_q, pend_eff_d;
  logic [CNT_W-1:0]  pend_slot_q, pend_slot_d;

  logic              out_valid_q;
  act_e              act_q;
  logic [EFF_W-1:0]  eff_out_q;
  logic [SLOT_W-1:0] slot_out_q;
  logic [MS_W-1:0]   play_q;
  logic              last_q;

  logic              out_ready;
  logic              emit;
  act_e              emit_act;
  logic [EFF_W-1:0]  emit_eff;
  logic [CNT_W-1:0]  emit_slot;
  logic [MS_W-1:0]   emit_play;
  logic              emit_last;

  logic [SIDX_W-1:0] sidx, midx, fidx;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign sidx = idx_q[SIDX_W-1:0];
  assign midx = match_q[SIDX_W-1:0];
  assign fidx = free_q[SIDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    eff_d       = eff_q;
    hold_d      = hold_q;
    rem_d       = rem_q;
    op_d        = op_q;
    idx_d       = idx_q;
    match_d     = match_q;
    free_d      = free_q;
    pend_v_d    = pend_v_q;
    pend_eff_d  = pend_eff_q;
    pend_slot_d = pend_slot_q;
    q_pop_o     = 1'b0;
    emit        = 1'b0;
    emit_act    = ACT_BADCMD;
    emit_eff    = op_q.effect;
    emit_slot   = NONE;
    emit_play   = '0;
    emit_last   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          op_d    = q_head_i;
          idx_d   = '0;
          match_d = NONE;
          free_d  = NONE;
          case (q_head_i.op)
            OP_TICK:   state_d = ST_TICK;
            OP_BADCMD: state_d = ST_APPLY;
            default:   state_d = ST_SCAN;
          endcase
        end
      end

      ST_SCAN: begin
        if (busy_q[sidx] && eff_q[sidx] == op_q.effect && match_q == NONE) begin
          match_d = idx_q;
        end
        if (!busy_q[sidx] && free_q == NONE) begin
          free_d = idx_q;
        end
        if (idx_q == LAST_IDX) begin
          state_d = ST_APPLY;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_APPLY: begin
        if (out_ready) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          case (op_q.op)
            OP_PRESS: begin
              if (match_q != NONE) begin
                if (hold_q[midx] != HOLD_MAX) begin
                  hold_d[midx] = hold_q[midx] + 1'b1;
                end
                emit_act  = ACT_EXTRA;
                emit_slot = match_q;
              end else if (free_q != NONE) begin
                busy_d[fidx] = 1'b1;
                eff_d[fidx]  = op_q.effect;
                hold_d[fidx] = HOLD_W'(1);
                rem_d[fidx]  = cfg_i.min_duration;
                emit_act     = ACT_START;
                emit_slot    = free_q;
                emit_play    = cfg_i.play_limit;
              end else begin
                emit_act = ACT_NOSLOT;
              end
            end
            OP_RELEASE: begin
              if (match_q != NONE && hold_q[midx] != '0) begin
                hold_d[midx] = hold_q[midx] - 1'b1;
              end
              emit_act  = ACT_RELEASED;
              emit_slot = match_q;
            end
            default: emit_act = ACT_BADCMD;
          endcase
        end
      end

      ST_TICK: begin
        logic advance;
        advance = 1'b1;
        if (busy_q[sidx]) begin
          if (rem_q[sidx] > op_q.elapsed) begin
            rem_d[sidx] = rem_q[sidx] - op_q.elapsed;
          end else if (hold_q[sidx] != '0) begin
            rem_d[sidx] = cfg_i.extend;
          end else if (pend_v_q && !out_ready) begin
            advance = 1'b0;
          end else begin
            if (pend_v_q) begin
              emit      = 1'b1;
              emit_act  = ACT_STOP;
              emit_eff  = pend_eff_q;
              emit_slot = pend_slot_q;
              emit_last = 1'b0;
            end
            pend_v_d     = 1'b1;
            pend_eff_d   = eff_q[sidx];
            pend_slot_d  = idx_q;
            busy_d[sidx] = 1'b0;
            eff_d[sidx]  = '0;
            hold_d[sidx] = '0;
            rem_d[sidx]  = '0;
          end
        end
        if (advance) begin
          if (idx_q == LAST_IDX) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_ready) begin
          emit      = 1'b1;
          emit_act  = ACT_STOP;
          emit_eff  = pend_eff_q;
          emit_slot = pend_slot_q;
          pend_v_d  = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      match_q     <= NONE;
      free_q      <= NONE;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        busy_q[i] <= 1'b0;
        eff_q[i]  <= '0;
        hold_q[i] <= '0;
        rem_q[i]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      match_q  <= match_d;
      free_q   <= free_d;
      pend_v_q <= pend_v_d;
      busy_q   <= busy_d;
      eff_q    <= eff_d;
      hold_q   <= hold_d;
      rem_q    <= rem_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    pend_eff_q  <= pend_eff_d;
    pend_slot_q <= pend_slot_d;
    if (emit) begin
      act_q      <= emit_act;
      eff_out_q  <= emit_eff;
      slot_out_q <= SLOT_W'(emit_slot);
      play_q     <= emit_play;
      last_q     <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = act_q;
  assign effect_out_o = eff_out_q;
  assign slot_out_o   = slot_out_q;
  assign play_ms_o    = play_q;
  assign last_o       = last_q;

  a_emit_when_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_ready)
    else $error("result overwrites a held item");

  a_pend_in_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (state_q == ST_TICK || state_q == ST_FLUSH))
    else $error("pending stop outside a tick walk");

  a_pop_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE && !q_empty_i))
    else $error("queue popped while busy");

  a_walk_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_TICK) |-> idx_q <= LAST_IDX)
    else $error("slot walk index out of range");

endmodule

`default_nettype wire
